/* rtl/core/assert_macros.svh */
// Assertion macros shared by the frustum cull tester RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define FCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: when ante holds, cons must follow.
`define FCT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) else $error(msg);

`endif

/* rtl/core/fct_pkg.sv */
// Shared constants, types and helper functions of the frustum cull tester.
`timescale 1ns / 1ps
package fct_pkg;

  localparam int CoordWidth       = 32;
  localparam int MatrixEntryWidth = 16;

  localparam int ActW    = 3;
  localparam int FieldW  = 32;
  localparam int RegW    = 64;
  localparam int PaddrW  = 5;
  localparam int SlotW   = 16;
  localparam int RawW    = SlotW + 1;
  localparam int NormW   = 18;
  localparam int OffW    = 48;
  localparam int Planes  = 6;
  localparam int PlaneAw = 3;
  localparam int RamW    = 3 * NormW + OffW;
  localparam int PtW     = FieldW + 2;
  localparam int ProdW   = PtW + NormW;
  localparam int DistW   = 64;
  localparam int NumW    = 48;
  localparam int LenW    = 32;

  typedef enum logic [ActW-1:0] {
    ActRebuild   = 3'd0,
    ActPoint     = 3'd1,
    ActSphere    = 3'd2,
    ActBoxMinMax = 3'd3,
    ActBoxCenter = 3'd4
  } action_e;

  // Coordinate field sign-extended from bit CoordWidth-1.
  function automatic logic signed [FieldW:0] coord_ext(input logic [FieldW-1:0] v);
    logic signed [CoordWidth-1:0] t;
    t = CoordWidth'(v);
    return (FieldW + 1)'(t);
  endfunction

  // Matrix entry taken from the low MatrixEntryWidth bits of a 16-bit slot.
  function automatic logic signed [RawW-1:0] entry_ext(input logic [SlotW-1:0] slot);
    logic signed [MatrixEntryWidth-1:0] e;
    e = MatrixEntryWidth'(slot);
    return RawW'(e);
  endfunction

endpackage

/* rtl/core/fct_if.sv */
// Item and result channel interfaces of the frustum cull tester.
`timescale 1ns / 1ps
interface fct_item_if import fct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ActW-1:0]   action;
  logic [FieldW-1:0] coord_a_x;
  logic [FieldW-1:0] coord_a_y;
  logic [FieldW-1:0] coord_a_z;
  logic [FieldW-1:0] coord_b_x;
  logic [FieldW-1:0] coord_b_y;
  logic [FieldW-1:0] coord_b_z;
  logic [FieldW-1:0] radius;

  modport source (output valid, action, coord_a_x, coord_a_y, coord_a_z,
                  coord_b_x, coord_b_y, coord_b_z, radius, input ready);
  modport sink (input valid, action, coord_a_x, coord_a_y, coord_a_z,
                coord_b_x, coord_b_y, coord_b_z, radius, output ready);
endinterface

interface fct_res_if import fct_pkg::*; ();
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

/* rtl/core/fct_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module fct_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/frustum_cull_tester_top.sv */
// Query: one stored plane read and tested per cycle.
// Rebuild: per plane the set-up states LOAD, SQR and SUM, 32 square-root steps and four
// bit-serial divisions; a zero-normal plane skips the root and the divisions.
// One item is worked on at a time; a new item is taken while a result still waits.
// Reset restores the identity matrix and marks all planes zero (valid bits, no sweep).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module frustum_cull_tester_top import fct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  fct_item_if.sink          item_i,
  fct_res_if.source         result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [RegW-1:0]   pwdata,
  output logic [RegW-1:0]   prdata,
  output logic              pready
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_SQR   = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_ROOT  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_WRITE = 9'b001000000,
    S_QRY   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

  localparam logic signed [NormW-1:0] NormOne = NormW'(16384);

  state_e state_q;

  // Configuration registers
  logic [RegW-1:0] mcol_q [4];
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = mcol_q[paddr[4:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcol_q[0] <= 64'h0000_0000_0000_1000;
      mcol_q[1] <= 64'h0000_0000_1000_0000;
      mcol_q[2] <= 64'h0000_1000_0000_0000;
      mcol_q[3] <= 64'h1000_0000_0000_0000;
    end else if (cfg_we) begin
      mcol_q[paddr[4:3]] <= pwdata;
    end
  end

  // Plane store
  logic               ram_we, ram_re;
  logic [PlaneAw-1:0] ram_raddr;
  logic [RamW-1:0]    ram_wdata, ram_rdata;
  logic [Planes-1:0]  valid_q;

  // Rebuild datapath
  logic [PlaneAw-1:0]             pl_q;
  logic signed [RawW-1:0]         raw [4];
  logic signed [RawW-1:0]         raw_q [4];
  logic signed [2*RawW-1:0]       sqp_q [3];
  logic [2*RawW:0]                sq_sum;
  logic [63:0]                    x_q, r_q, bit_q, root_sum, r_next;
  logic [LenW-1:0]                len_q;
  logic [1:0]                     dj_q;
  logic                           dgo_q;
  logic [5:0]                     dcnt_q;
  logic [NumW-1:0]                num_q, quo_q, quo_next, div_num;
  logic [LenW:0]                  rem_q, rem_sh;
  logic                           neg_q, qbit;
  logic [RawW-1:0]                div_mag;
  logic signed [RawW-1:0]         div_src;
  logic signed [NumW-1:0]         quo_signed;
  logic signed [NormW-1:0]        nrm_q [3];
  logic signed [OffW-1:0]         off_q;

  // Query datapath
  logic signed [PtW-1:0]          pa_q [3];
  logic signed [PtW-1:0]          pb_q [3];
  logic signed [PtW-1:0]          pt [3];
  logic signed [FieldW:0]         ca [3];
  logic signed [FieldW:0]         cb [3];
  logic signed [DistW-1:0]        rterm_q, offt_q, dist_sum;
  logic                           box_q, rval_q, rv_q, pv_q, ins_q;
  logic [2:0]                     iss_cnt_q;
  logic [RamW-1:0]                pdata;
  logic signed [NormW-1:0]        pn [3];
  logic signed [ProdW-1:0]        prod_q [3];
  logic                           res_valid_q, res_q, item_acc, res_load;

  // Raw plane: row 3 of each column plus or minus row k.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic signed [RawW-1:0] e3, ek;
      e3 = entry_ext(mcol_q[c][48 +: SlotW]);
      ek = entry_ext(mcol_q[c][{pl_q[2:1], 4'b0000} +: SlotW]);
      raw[c] = pl_q[0] ? RawW'(e3 - ek) : RawW'(e3 + ek);
    end
  end

  assign sq_sum = (2*RawW+1)'(unsigned'(sqp_q[0])) + (2*RawW+1)'(unsigned'(sqp_q[1]))
                + (2*RawW+1)'(unsigned'(sqp_q[2]));

  // Bit-pair square root step.
  assign root_sum = r_q + bit_q;
  assign r_next   = (x_q >= root_sum) ? ((r_q >> 1) + bit_q) : (r_q >> 1);

  // Rounded division set-up and restoring step.
  assign div_src  = raw_q[dj_q];
  assign div_mag  = div_src[RawW-1] ? RawW'(-div_src) : RawW'(div_src);
  assign div_num  = ((dj_q == 2'd3) ? (NumW'(div_mag) << 30) : (NumW'(div_mag) << 28))
                  + NumW'(len_q >> 1);
  assign rem_sh   = {rem_q[LenW-1:0], num_q[NumW-1]};
  assign qbit     = (rem_sh >= {1'b0, len_q});
  assign quo_next = {quo_q[NumW-2:0], qbit};
  assign quo_signed = neg_q ? NumW'(-signed'(quo_next)) : signed'(quo_next);

  // Query: plane read back, unwritten planes read as zero.
  assign pdata = rval_q ? ram_rdata : '0;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pn[c] = signed'(pdata[c*NormW +: NormW]);
      pt[c] = (box_q && !pn[c][NormW-1]) ? pb_q[c] : pa_q[c];
    end
  end
  assign dist_sum = DistW'(prod_q[0]) + DistW'(prod_q[1]) + DistW'(prod_q[2]) + offt_q
                  + rterm_q;

  assign item_i.ready = (state_q == S_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;
  assign res_load     = (state_q == S_FIN) && (!res_valid_q || result_o.ready);

  always_comb begin
    ca[0] = coord_ext(item_i.coord_a_x);
    ca[1] = coord_ext(item_i.coord_a_y);
    ca[2] = coord_ext(item_i.coord_a_z);
    cb[0] = coord_ext(item_i.coord_b_x);
    cb[1] = coord_ext(item_i.coord_b_y);
    cb[2] = coord_ext(item_i.coord_b_z);
  end

  assign ram_re    = (state_q == S_QRY) && (iss_cnt_q < 3'(Planes));
  assign ram_raddr = iss_cnt_q;
  assign ram_we    = (state_q == S_WRITE);
  assign ram_wdata = {off_q, nrm_q[2], nrm_q[1], nrm_q[0]};

  fct_ram #(
    .Width (RamW),
    .Depth (Planes)
  ) u_plane_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pl_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pl_q        <= '0;
      dj_q        <= '0;
      dgo_q       <= 1'b0;
      iss_cnt_q   <= '0;
      rv_q        <= 1'b0;
      pv_q        <= 1'b0;
      res_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      rv_q <= ram_re;
      pv_q <= rv_q;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (item_acc) begin
            iss_cnt_q <= '0;
            pl_q      <= '0;
            case (item_i.action) inside
              ActRebuild:                 state_q <= S_LOAD;
              [ActPoint:ActBoxCenter]:    state_q <= S_QRY;
              default:                    state_q <= S_FIN;
            endcase
          end
        end
        S_LOAD:  state_q <= S_SQR;
        S_SQR:   state_q <= S_SUM;
        S_SUM:   state_q <= (sq_sum == '0) ? S_WRITE : S_ROOT;
        S_ROOT: begin
          if (bit_q[0]) begin
            state_q <= S_DIV;
            dj_q    <= '0;
            dgo_q   <= 1'b0;
          end
        end
        S_DIV: begin
          if (!dgo_q) begin
            dgo_q <= 1'b1;
          end else if (dcnt_q == 6'(NumW - 1)) begin
            dgo_q <= 1'b0;
            dj_q  <= dj_q + 2'd1;
            if (dj_q == 2'd3) begin
              state_q <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          valid_q[pl_q] <= 1'b1;
          if (pl_q == PlaneAw'(Planes - 1)) begin
            state_q <= S_FIN;
          end else begin
            pl_q    <= pl_q + 3'd1;
            state_q <= S_LOAD;
          end
        end
        S_QRY: begin
          if (ram_re) begin
            iss_cnt_q <= iss_cnt_q + 3'd1;
          end else if (!rv_q && !pv_q) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rval_q <= valid_q[ram_raddr];
    if (item_acc) begin
      box_q <= (item_i.action == ActBoxMinMax) || (item_i.action == ActBoxCenter);
      ins_q <= (item_i.action == ActPoint) || (item_i.action == ActSphere)
            || (item_i.action == ActBoxMinMax) || (item_i.action == ActBoxCenter);
      rterm_q <= (item_i.action == ActSphere) ? (DistW'(coord_ext(item_i.radius)) <<< 14)
                                              : '0;
      for (int c = 0; c < 3; c++) begin
        if (item_i.action == ActBoxCenter) begin
          pa_q[c] <= PtW'(ca[c]) - PtW'(cb[c]);
          pb_q[c] <= PtW'(ca[c]) + PtW'(cb[c]);
        end else begin
          pa_q[c] <= PtW'(ca[c]);
          pb_q[c] <= PtW'(cb[c]);
        end
      end
    end
    if (rv_q) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= ProdW'(pt[c]) * ProdW'(pn[c]);
      end
      offt_q <= DistW'(signed'(pdata[3*NormW +: OffW])) <<< 14;
    end
    if (pv_q && dist_sum[DistW-1]) begin
      ins_q <= 1'b0;
    end
    if (res_load) begin
      res_q <= ins_q;
    end
    case (state_q)
      S_LOAD: begin
        for (int c = 0; c < 4; c++) begin
          raw_q[c] <= raw[c];
        end
      end
      S_SQR: begin
        for (int c = 0; c < 3; c++) begin
          sqp_q[c] <= raw_q[c] * raw_q[c];
        end
      end
      S_SUM: begin
        // A zero normal keeps its raw offset, rescaled to Q.16.
        for (int c = 0; c < 3; c++) begin
          nrm_q[c] <= '0;
        end
        off_q <= OffW'(raw_q[3]) <<< 4;
        x_q   <= 64'(sq_sum) << 28;
        r_q   <= '0;
        bit_q <= 64'd1 << 62;
      end
      S_ROOT: begin
        if (x_q >= root_sum) begin
          x_q <= x_q - root_sum;
        end
        r_q   <= r_next;
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          len_q <= r_next[LenW-1:0];
        end
      end
      S_DIV: begin
        if (!dgo_q) begin
          num_q  <= div_num;
          neg_q  <= div_src[RawW-1];
          rem_q  <= '0;
          quo_q  <= '0;
          dcnt_q <= '0;
        end else begin
          num_q  <= num_q << 1;
          rem_q  <= qbit ? (rem_sh - {1'b0, len_q}) : rem_sh;
          quo_q  <= quo_next;
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'(NumW - 1)) begin
            if (dj_q == 2'd3) begin
              off_q <= OffW'(quo_signed);
            end else begin
              nrm_q[dj_q] <= NormW'(quo_signed);
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign result_o.valid      = res_valid_q;
  assign result_o.inside_res = res_q;

  `FCT_ASSERT_IMPL(a_accept_leaves_idle, item_acc, ##1 (state_q != S_IDLE), "item accepted but sequencer stayed idle")
  `FCT_ASSERT_IMPL(a_norm_range, state_q == S_WRITE, (nrm_q[0] >= -NormOne && nrm_q[0] <= NormOne && nrm_q[1] >= -NormOne && nrm_q[1] <= NormOne && nrm_q[2] >= -NormOne && nrm_q[2] <= NormOne), "normalised plane component exceeds unit length")
  `FCT_ASSERT_IMPL(a_fin_loads_result, res_load, ##1 result_o.valid, "finished item did not reach the output register")

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the frustum cull tester: plane rebuilds and culling queries.
`timescale 1ns / 1ps
module tb_top;
  import fct_pkg::*;

  localparam logic [ActW-1:0] ActSpare5 = 3'd5;
  localparam logic [ActW-1:0] ActSpare6 = 3'd6;
  localparam logic [ActW-1:0] ActSpare7 = 3'd7;
  localparam logic [PaddrW-1:0] AddrCol0 = 5'd0;
  localparam logic [PaddrW-1:0] AddrCol1 = 5'd8;
  localparam logic [PaddrW-1:0] AddrCol2 = 5'd16;
  localparam logic [PaddrW-1:0] AddrCol3 = 5'd24;
  localparam int SettleCycles = 40;

  typedef struct packed {
    logic [ActW-1:0]   act;
    logic [FieldW-1:0] ax, ay, az, bx, by, bz, rad;
  } cull_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [RegW-1:0] pwdata = '0;
  logic [RegW-1:0] prdata;
  logic pready;

  fct_item_if item_bus ();
  fct_res_if  res_bus ();

  frustum_cull_tester_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .item_i(item_bus), .result_o(res_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow state of the block.
  logic [RegW-1:0] mat_col [4];
  longint plane_n [6][3];
  longint plane_d [6];
  logic verdicts [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  initial begin
    item_bus.valid = 1'b0;
    item_bus.action = '0;
    item_bus.coord_a_x = '0; item_bus.coord_a_y = '0; item_bus.coord_a_z = '0;
    item_bus.coord_b_x = '0; item_bus.coord_b_y = '0; item_bus.coord_b_z = '0;
    item_bus.radius = '0;
    res_bus.ready = 1'b0;
  end

  function automatic longint entry(int col, int row);
    logic signed [15:0] e;
    e = mat_col[col][16*row +: 16];
    return longint'(e);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint div_round(longint num, longint unsigned den);
    longint unsigned mag;
    longint q;
    mag = (num < 0) ? longint'(-num) : num;
    q = longint'((mag + den / 2) / den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic void rebuild_planes();
    longint a [3];
    longint d, s;
    longint unsigned sq, len;
    int k;
    for (int p = 0; p < Planes; p++) begin
      k = p >> 1;
      s = (p & 1) ? -1 : 1;
      sq = 0;
      for (int c = 0; c < 3; c++) begin
        a[c] = entry(c, 3) + s * entry(c, k);
        sq += longint'(a[c] * a[c]);
      end
      d = entry(3, 3) + s * entry(3, k);
      if (sq == 0) begin
        for (int c = 0; c < 3; c++) plane_n[p][c] = 0;
        plane_d[p] = d * 16;
      end else begin
        len = int_sqrt(sq << 28);
        for (int c = 0; c < 3; c++) plane_n[p][c] = div_round(a[c] * (64'sd1 <<< 28), len);
        plane_d[p] = div_round(d * (64'sd1 <<< 30), len);
      end
    end
  endfunction

  function automatic longint plane_dist(int p, longint pt [3]);
    return plane_n[p][0] * pt[0] + plane_n[p][1] * pt[1] + plane_n[p][2] * pt[2]
         + plane_d[p] * 16384;
  endfunction

  // Works out the verdict of one item and applies any plane rebuild.
  function automatic logic cull_verdict(cull_item_t it);
    longint lo [3], hi [3], pt [3];
    longint r, dist_v;
    logic in_view;
    in_view = 1'b1;
    if (it.act == ActRebuild) begin
      rebuild_planes();
      return 1'b0;
    end
    if (it.act > ActBoxCenter) return 1'b0;
    lo[0] = longint'($signed(it.ax)); lo[1] = longint'($signed(it.ay));
    lo[2] = longint'($signed(it.az));
    hi[0] = longint'($signed(it.bx)); hi[1] = longint'($signed(it.by));
    hi[2] = longint'($signed(it.bz));
    r = longint'($signed(it.rad));
    if (it.act == ActBoxCenter) begin
      for (int c = 0; c < 3; c++) begin
        pt[c] = lo[c] - hi[c];
        hi[c] = lo[c] + hi[c];
        lo[c] = pt[c];
      end
    end
    for (int p = 0; p < Planes && in_view; p++) begin
      if (it.act == ActPoint || it.act == ActSphere) begin
        dist_v = plane_dist(p, lo);
        if (it.act == ActSphere) dist_v += r * 16384;
      end else begin
        for (int c = 0; c < 3; c++) pt[c] = (plane_n[p][c] >= 0) ? hi[c] : lo[c];
        dist_v = plane_dist(p, pt);
      end
      if (dist_v < 0) in_view = 1'b0;
    end
    return in_view;
  endfunction

  task automatic reg_write(logic [PaddrW-1:0] addr, logic [RegW-1:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mat_col[addr >> 3] = data;
  endtask

  task automatic load_matrix(logic [RegW-1:0] c0, c1, c2, c3);
    reg_write(AddrCol0, c0);
    reg_write(AddrCol1, c1);
    reg_write(AddrCol2, c2);
    reg_write(AddrCol3, c3);
  endtask

  task automatic send_item(cull_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_bus.valid <= 1'b1;
    item_bus.action <= it.act;
    item_bus.coord_a_x <= it.ax; item_bus.coord_a_y <= it.ay; item_bus.coord_a_z <= it.az;
    item_bus.coord_b_x <= it.bx; item_bus.coord_b_y <= it.by; item_bus.coord_b_z <= it.bz;
    item_bus.radius <= it.rad;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    verdicts.push_back(cull_verdict(it));
  endtask

  // Lowers valid and waits for every verdict, then lets the block settle.
  task automatic drain();
    item_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic cull_item_t mk(logic [ActW-1:0] act, int ax, ay, az, bx, by, bz, rad);
    cull_item_t it;
    it.act = act;
    it.ax = ax; it.ay = ay; it.az = az; it.bx = bx; it.by = by; it.bz = bz; it.rad = rad;
    return it;
  endfunction

  always @(posedge clk_i) begin
    logic want;
    if (res_bus.valid && res_bus.ready) begin
      if (verdicts.size() == 0) begin
        $error("inside_res: no beat expected, got %0b", res_bus.inside_res);
        errors++;
      end else begin
        want = verdicts.pop_front();
        if (res_bus.inside_res !== want) begin
          $error("inside_res: expected %0b, got %0b", want, res_bus.inside_res);
          errors++;
        end
      end
    end
    res_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [FieldW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return FieldW'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
      default: return FieldW'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  function automatic logic [RegW-1:0] rand_column();
    logic [RegW-1:0] v;
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(3) == 0) v[16*i +: 16] = $urandom;
      else if ($urandom_range(2) == 0) v[16*i +: 16] = '0;
      else v[16*i +: 16] = 16'($signed($urandom_range(16384)) - 8192);
    end
    return v;
  endfunction

  task automatic test_before_rebuild();
    send_item(mk(ActPoint, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 0));
    send_item(mk(ActSphere, 0, 0, 0, 0, 0, 0, -1));
    send_item(mk(ActSphere, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff));
    send_item(mk(ActBoxMinMax, 5, 5, 5, -5, -5, -5, 0));
    send_item(mk(ActBoxCenter, 0, 0, 0, 32'h8000_0000, 1, 1, 0));
    drain();
  endtask

  task automatic test_identity_planes();
    send_item(mk(ActRebuild, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(ActPoint, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(ActPoint, 32'h0002_0000, 0, 0, 0, 0, 0, 0));
    send_item(mk(ActSphere, 32'h0002_0000, 0, 0, 0, 0, 0, 32'h0001_8000));
    send_item(mk(ActSphere, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
    // Minimum above maximum is tested as given.
    send_item(mk(ActBoxMinMax, 32'h0003_0000, 0, 0, 32'h0002_0000, 0, 0, 0));
    send_item(mk(ActBoxCenter, 32'h0005_0000, 0, 0, 32'h0004_8000, 0, 0, 0));
    send_item(mk(ActSpare5, -1, -1, -1, -1, -1, -1, -1));
    send_item(mk(ActSpare6, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(ActSpare7, 0, 0, 0, 0, 0, 0, 0));
    drain();
  endtask

  task automatic test_zero_normals();
    load_matrix(64'h0, 64'h0, 64'h0, {16'h7fff, 16'h8000, 16'h1234, 16'hffff});
    send_item(mk(ActRebuild, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(ActPoint, 1, 2, 3, 0, 0, 0, 0));
    send_item(mk(ActSphere, 1, 2, 3, 0, 0, 0, 32'h7fff_ffff));
    drain();
  endtask

  task automatic test_matrix_extremes();
    load_matrix({4{16'h8000}}, {4{16'h7fff}}, {4{16'hffff}}, {4{16'h8000}});
    send_item(mk(ActRebuild, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(ActBoxMinMax, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0));
    send_item(mk(ActBoxCenter, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0));
    send_item(mk(ActPoint, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0));
    drain();
  endtask

  task automatic test_random_phase(int idle, int stall, int count);
    cull_item_t it;
    idle_pct = idle;
    stall_pct = stall;
    load_matrix(rand_column(), rand_column(), rand_column(), rand_column());
    send_item(mk(ActRebuild, 0, 0, 0, 0, 0, 0, 0));
    for (int n = 0; n < count; n++) begin
      it.act = ActW'($urandom_range(ActBoxCenter, ActPoint));
      if ($urandom_range(29) == 0) it.act = ActRebuild;
      if ($urandom_range(39) == 0) it.act = ActW'($urandom_range(7, 5));
      it.ax = rand_coord(); it.ay = rand_coord(); it.az = rand_coord();
      it.bx = rand_coord(); it.by = rand_coord(); it.bz = rand_coord();
      it.rad = rand_coord();
      send_item(it);
    end
    drain();
  endtask

  initial begin
    mat_col[0] = 64'd4096;
    mat_col[1] = 64'd4096 << 16;
    mat_col[2] = 64'd4096 << 32;
    mat_col[3] = 64'd4096 << 48;
    for (int p = 0; p < Planes; p++) begin
      plane_n[p][0] = 0; plane_n[p][1] = 0; plane_n[p][2] = 0;
      plane_d[p] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_before_rebuild();
    test_identity_planes();
    test_zero_normals();
    test_matrix_extremes();
    for (int rep = 0; rep < 2; rep++) begin
      test_random_phase(0, 0, 150);
      test_random_phase(65, 0, 150);
      test_random_phase(0, 65, 150);
      test_random_phase(27, 27, 150);
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
